### hdl/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg: shared types and constants for the box collide/resolve pipeline
// Field widths, fixed-point grid constants, register indexes and the
// per-stage advance enables passed between the pipeline modules.
// ----------------------------------------------------------------------------
package acr_pkg;

    // fixed point: Q15.8 positions, Q14.8 half extents
    localparam int FRAC_BITS = 8;

    localparam int POS_W  = 24;  // signed center
    localparam int HALF_W = 22;  // unsigned half extent
    localparam int EXT_W  = 26;  // box bounds, signed
    localparam int DIFF_W = 27;  // differences of bounds
    localparam int OV_W   = 24;  // clamped overlap, at most 2 * half
    localparam int TGT_W  = 26;  // snapped target position
    localparam int MOVE_W = 25;  // push amount
    localparam int AXIS_W = 2;
    localparam int IDX_W  = 2;   // config register index

    localparam int NUM_STAGES = 6;

    // half extent reset: 1.0
    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(1 << FRAC_BITS);

    // grid fraction mask (all fraction bits)
    localparam logic signed [TGT_W-1:0] GRID_MASK = TGT_W'((1 << FRAC_BITS) - 1);

    // config register indexes
    localparam logic [IDX_W-1:0] REG_OWN_HALF_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_OWN_HALF_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_OWN_HALF_Z = 2'd2;

    // axis codes
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // stage load enables, stage 1 first
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
        logic en5;
        logic en6;
    } pipe_en_t;

endpackage

### hdl/aabb_collide_resolve.sv
// ----------------------------------------------------------------------------
// aabb_collide_resolve: box overlap test and minimum-penetration resolve
// Six register stages from input accept to result valid.
// Throughput: one item per cycle; the slowest stage is a 26/27-bit
// add or compare, and a stall holds every stage that cannot move on.
// Reset: clears all stage valid bits and sets the own half extents to 1.0.
// ----------------------------------------------------------------------------
//
// Stages
//   1  box bounds per axis (center -/+ half extent), center order flag
//   2  separation test, min of maxima and max of minima
//   3  overlap = hi - lo, clamped at zero
//   4  pick axis of smallest overlap (ties to x, then y), hit flag
//   5  snap target on the unit grid: floor(pos + ov) when own center is
//      greater than the peer center, else ceil(pos - ov)
//   6  move = target - pos, new center saturated to 24 bits
//
// Flow control: each stage loads when it is empty or the stage after it
// loads, so bubbles close up and in_ready only drops once every stage
// holds an item and the output is stalled. The snap is applied even
// when the boxes do not touch.
//
// Config: three half extent registers; the user writes them only while
// the pipe is idle, not enforced; a write past the third index is dropped.
// ----------------------------------------------------------------------------
module aabb_collide_resolve
(
    input  logic                               clk,
    input  logic                               rst_n,
    // config write port
    input  logic                               cfg_we,
    input  logic        [acr_pkg::IDX_W-1:0]   cfg_addr,
    input  logic        [acr_pkg::HALF_W-1:0]  cfg_wdata,
    // input item
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [acr_pkg::POS_W-1:0]   own_x,
    input  logic signed [acr_pkg::POS_W-1:0]   own_y,
    input  logic signed [acr_pkg::POS_W-1:0]   own_z,
    input  logic signed [acr_pkg::POS_W-1:0]   peer_x,
    input  logic signed [acr_pkg::POS_W-1:0]   peer_y,
    input  logic signed [acr_pkg::POS_W-1:0]   peer_z,
    input  logic        [acr_pkg::HALF_W-1:0]  peer_half_x,
    input  logic        [acr_pkg::HALF_W-1:0]  peer_half_y,
    input  logic        [acr_pkg::HALF_W-1:0]  peer_half_z,
    // result item
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic        [acr_pkg::AXIS_W-1:0]  push_axis,
    output logic signed [acr_pkg::MOVE_W-1:0]  push_amount,
    output logic signed [acr_pkg::POS_W-1:0]   new_x,
    output logic signed [acr_pkg::POS_W-1:0]   new_y,
    output logic signed [acr_pkg::POS_W-1:0]   new_z
);
    import acr_pkg::*;

    // config registers
    logic [HALF_W-1:0] own_half_x_reg, own_half_y_reg, own_half_z_reg;

    // stage valid bits, index 0 is stage 1
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   stage_rdy;
    pipe_en_t              en;

    // per-axis results at stage 3
    logic [OV_W-1:0]         ov_x, ov_y, ov_z;
    logic                    sep_x, sep_y, sep_z;
    logic                    gt_x, gt_y, gt_z;
    logic signed [POS_W-1:0] p3_x, p3_y, p3_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_half_x_reg <= HALF_RESET;
            own_half_y_reg <= HALF_RESET;
            own_half_z_reg <= HALF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_OWN_HALF_X: own_half_x_reg <= cfg_wdata;
                REG_OWN_HALF_Y: own_half_y_reg <= cfg_wdata;
                REG_OWN_HALF_Z: own_half_z_reg <= cfg_wdata;
                default:        ;  // unmapped index: write dropped
            endcase
        end
    end

    // a stage may load when it is empty or its item moves on
    always_comb
    begin
        stage_rdy[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];

        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (stage_rdy[k])
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            else
                valid_next[k] = valid_reg[k];
        end

        en.en1 = stage_rdy[0];
        en.en2 = stage_rdy[1];
        en.en3 = stage_rdy[2];
        en.en4 = stage_rdy[3];
        en.en5 = stage_rdy[4];
        en.en6 = stage_rdy[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = stage_rdy[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    acr_axis_ovl u_axis_x
    (
        .clk       (clk),
        .en        (en),
        .pos       (own_x),
        .peer      (peer_x),
        .own_half  (own_half_x_reg),
        .peer_half (peer_half_x),
        .ov        (ov_x),
        .sep       (sep_x),
        .gt        (gt_x),
        .pos_out   (p3_x)
    );

    acr_axis_ovl u_axis_y
    (
        .clk       (clk),
        .en        (en),
        .pos       (own_y),
        .peer      (peer_y),
        .own_half  (own_half_y_reg),
        .peer_half (peer_half_y),
        .ov        (ov_y),
        .sep       (sep_y),
        .gt        (gt_y),
        .pos_out   (p3_y)
    );

    acr_axis_ovl u_axis_z
    (
        .clk       (clk),
        .en        (en),
        .pos       (own_z),
        .peer      (peer_z),
        .own_half  (own_half_z_reg),
        .peer_half (peer_half_z),
        .ov        (ov_z),
        .sep       (sep_z),
        .gt        (gt_z),
        .pos_out   (p3_z)
    );

    acr_snap u_snap
    (
        .clk         (clk),
        .en          (en),
        .ov_x        (ov_x),
        .ov_y        (ov_y),
        .ov_z        (ov_z),
        .sep_x       (sep_x),
        .sep_y       (sep_y),
        .sep_z       (sep_z),
        .gt_x        (gt_x),
        .gt_y        (gt_y),
        .gt_z        (gt_z),
        .pos_x       (p3_x),
        .pos_y       (p3_y),
        .pos_z       (p3_z),
        .hit         (hit),
        .push_axis   (push_axis),
        .push_amount (push_amount),
        .new_x       (new_x),
        .new_y       (new_y),
        .new_z       (new_z)
    );

endmodule

### hdl/acr_axis_ovl.sv
// ----------------------------------------------------------------------------
// acr_axis_ovl: per-axis bounds, separation test and clamped overlap
// Three register stages: bounds, min/max of bounds, overlap subtract.
// ----------------------------------------------------------------------------
module acr_axis_ovl
(
    input  logic                               clk,
    input  acr_pkg::pipe_en_t                  en,
    input  logic signed [acr_pkg::POS_W-1:0]   pos,
    input  logic signed [acr_pkg::POS_W-1:0]   peer,
    input  logic        [acr_pkg::HALF_W-1:0]  own_half,
    input  logic        [acr_pkg::HALF_W-1:0]  peer_half,
    output logic        [acr_pkg::OV_W-1:0]    ov,
    output logic                               sep,
    output logic                               gt,
    output logic signed [acr_pkg::POS_W-1:0]   pos_out
);
    import acr_pkg::*;

    logic signed [EXT_W-1:0] pos_e;
    logic signed [EXT_W-1:0] peer_e;
    logic signed [EXT_W-1:0] ha_e;
    logic signed [EXT_W-1:0] hb_e;

    // stage 1
    logic signed [EXT_W-1:0] mina_reg, maxa_reg, minb_reg, maxb_reg;
    logic                    gt1_reg;
    logic signed [POS_W-1:0] pos1_reg;
    // stage 2
    logic signed [EXT_W-1:0] hi_reg, lo_reg;
    logic                    sep2_reg, gt2_reg;
    logic signed [POS_W-1:0] pos2_reg;
    logic signed [EXT_W-1:0] hi_next, lo_next;
    logic                    sep_next;
    // stage 3
    logic signed [DIFF_W-1:0] d;
    logic        [OV_W-1:0]   ov_next;
    logic        [OV_W-1:0]   ov3_reg;
    logic                     sep3_reg, gt3_reg;
    logic signed [POS_W-1:0]  pos3_reg;

    assign pos_e  = EXT_W'(pos);
    assign peer_e = EXT_W'(peer);
    assign ha_e   = EXT_W'(own_half);
    assign hb_e   = EXT_W'(peer_half);

    always_ff @(posedge clk)
    begin
        if (en.en1)
        begin
            mina_reg <= pos_e - ha_e;
            maxa_reg <= pos_e + ha_e;
            minb_reg <= peer_e - hb_e;
            maxb_reg <= peer_e + hb_e;
            gt1_reg  <= (pos > peer);
            pos1_reg <= pos;
        end
    end

    always_comb
    begin
        sep_next = (maxa_reg < minb_reg) || (mina_reg > maxb_reg);
        hi_next  = (maxa_reg < maxb_reg) ? maxa_reg : maxb_reg;
        lo_next  = (mina_reg > minb_reg) ? mina_reg : minb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.en2)
        begin
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            sep2_reg <= sep_next;
            gt2_reg  <= gt1_reg;
            pos2_reg <= pos1_reg;
        end
    end

    // overlap never exceeds twice the own half extent, so it fits OV_W
    always_comb
    begin
        d       = DIFF_W'(hi_reg) - DIFF_W'(lo_reg);
        ov_next = d[DIFF_W-1] ? '0 : d[OV_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.en3)
        begin
            ov3_reg  <= ov_next;
            sep3_reg <= sep2_reg;
            gt3_reg  <= gt2_reg;
            pos3_reg <= pos2_reg;
        end
    end

    assign ov      = ov3_reg;
    assign sep     = sep3_reg;
    assign gt      = gt3_reg;
    assign pos_out = pos3_reg;

endmodule

### hdl/acr_snap.sv
// ----------------------------------------------------------------------------
// acr_snap: axis pick, grid snap and result assembly
// Three register stages: axis select, snapped target, move and new centers.
// ----------------------------------------------------------------------------
module acr_snap
(
    input  logic                               clk,
    input  acr_pkg::pipe_en_t                  en,
    input  logic        [acr_pkg::OV_W-1:0]    ov_x,
    input  logic        [acr_pkg::OV_W-1:0]    ov_y,
    input  logic        [acr_pkg::OV_W-1:0]    ov_z,
    input  logic                               sep_x,
    input  logic                               sep_y,
    input  logic                               sep_z,
    input  logic                               gt_x,
    input  logic                               gt_y,
    input  logic                               gt_z,
    input  logic signed [acr_pkg::POS_W-1:0]   pos_x,
    input  logic signed [acr_pkg::POS_W-1:0]   pos_y,
    input  logic signed [acr_pkg::POS_W-1:0]   pos_z,
    output logic                               hit,
    output logic        [acr_pkg::AXIS_W-1:0]  push_axis,
    output logic signed [acr_pkg::MOVE_W-1:0]  push_amount,
    output logic signed [acr_pkg::POS_W-1:0]   new_x,
    output logic signed [acr_pkg::POS_W-1:0]   new_y,
    output logic signed [acr_pkg::POS_W-1:0]   new_z
);
    import acr_pkg::*;

    localparam logic signed [TGT_W-1:0] POS_MAX = TGT_W'((1 << (POS_W - 1)) - 1);
    localparam logic signed [TGT_W-1:0] POS_MIN = -TGT_W'(1 << (POS_W - 1));

    // stage 4
    logic [AXIS_W-1:0]       axis_next;
    logic [OV_W-1:0]         ov_sel;
    logic signed [POS_W-1:0] pos_sel;
    logic                    gt_sel;
    logic [AXIS_W-1:0]       axis4_reg;
    logic [OV_W-1:0]         ov4_reg;
    logic signed [POS_W-1:0] psel4_reg;
    logic                    gt4_reg, hit4_reg;
    logic signed [POS_W-1:0] px4_reg, py4_reg, pz4_reg;
    // stage 5
    logic signed [TGT_W-1:0] p_e, o_e, tgt_next;
    logic signed [TGT_W-1:0] tgt5_reg;
    logic [AXIS_W-1:0]       axis5_reg;
    logic signed [POS_W-1:0] psel5_reg;
    logic                    hit5_reg;
    logic signed [POS_W-1:0] px5_reg, py5_reg, pz5_reg;
    // stage 6
    logic signed [DIFF_W-1:0] move_full;
    logic signed [POS_W-1:0]  snapped;
    logic                     hit6_reg;
    logic [AXIS_W-1:0]        axis6_reg;
    logic signed [MOVE_W-1:0] move6_reg;
    logic signed [POS_W-1:0]  nx6_reg, ny6_reg, nz6_reg;

    // smallest overlap, ties to x then y
    always_comb
    begin
        priority if (ov_x <= ov_y && ov_x <= ov_z)
        begin
            axis_next = AXIS_X;
            ov_sel    = ov_x;
            pos_sel   = pos_x;
            gt_sel    = gt_x;
        end
        else if (ov_y <= ov_z)
        begin
            axis_next = AXIS_Y;
            ov_sel    = ov_y;
            pos_sel   = pos_y;
            gt_sel    = gt_y;
        end
        else
        begin
            axis_next = AXIS_Z;
            ov_sel    = ov_z;
            pos_sel   = pos_z;
            gt_sel    = gt_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.en4)
        begin
            axis4_reg <= axis_next;
            ov4_reg   <= ov_sel;
            psel4_reg <= pos_sel;
            gt4_reg   <= gt_sel;
            hit4_reg  <= !(sep_x || sep_y || sep_z);
            px4_reg   <= pos_x;
            py4_reg   <= pos_y;
            pz4_reg   <= pos_z;
        end
    end

    // floor clears the fraction; ceil adds the mask first
    always_comb
    begin
        p_e = TGT_W'(psel4_reg);
        o_e = TGT_W'(ov4_reg);
        if (gt4_reg)
            tgt_next = (p_e + o_e) & ~GRID_MASK;
        else
            tgt_next = (p_e - o_e + GRID_MASK) & ~GRID_MASK;
    end

    always_ff @(posedge clk)
    begin
        if (en.en5)
        begin
            tgt5_reg  <= tgt_next;
            axis5_reg <= axis4_reg;
            psel5_reg <= psel4_reg;
            hit5_reg  <= hit4_reg;
            px5_reg   <= px4_reg;
            py5_reg   <= py4_reg;
            pz5_reg   <= pz4_reg;
        end
    end

    // the move stays within one grid unit of the overlap, so it always
    // fits MOVE_W; pos + move is then the target itself
    always_comb
    begin
        move_full = DIFF_W'(tgt5_reg) - DIFF_W'(psel5_reg);
        if (tgt5_reg > POS_MAX)
            snapped = POS_MAX[POS_W-1:0];
        else if (tgt5_reg < POS_MIN)
            snapped = POS_MIN[POS_W-1:0];
        else
            snapped = tgt5_reg[POS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.en6)
        begin
            hit6_reg  <= hit5_reg;
            axis6_reg <= axis5_reg;
            move6_reg <= move_full[MOVE_W-1:0];
            nx6_reg   <= (axis5_reg == AXIS_X) ? snapped : px5_reg;
            ny6_reg   <= (axis5_reg == AXIS_Y) ? snapped : py5_reg;
            nz6_reg   <= (axis5_reg == AXIS_Z) ? snapped : pz5_reg;
        end
    end

    assign hit         = hit6_reg;
    assign push_axis   = axis6_reg;
    assign push_amount = move6_reg;
    assign new_x       = nx6_reg;
    assign new_y       = ny6_reg;
    assign new_z       = nz6_reg;

endmodule

### sim/aabb_collide_resolve_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_collide_resolve_test: self-checking bench for the box collide/resolve
// Streams box pairs through the pipe under several half-extent settings and
// idle/stall mixes, predicts each resolution in the bench and compares every
// result field against the oldest prediction.
// ----------------------------------------------------------------------------
module aabb_collide_resolve_test;
    import acr_pkg::*;

    // field extremes
    localparam logic signed [POS_W-1:0] POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic        [HALF_W-1:0] HALF_MAX = '1;
    localparam logic        [HALF_W-1:0] HALF_ONE = HALF_W'(1 << FRAC_BITS);

    // index with no register behind it; writes there must be dropped
    localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

    localparam longint GRID_UNIT   = longint'(1) << FRAC_BITS;
    localparam int     DUT_LATENCY = 6;

    // one box pair as presented on the input channel
    typedef struct packed {
        logic signed [POS_W-1:0]  own_x;
        logic signed [POS_W-1:0]  own_y;
        logic signed [POS_W-1:0]  own_z;
        logic signed [POS_W-1:0]  peer_x;
        logic signed [POS_W-1:0]  peer_y;
        logic signed [POS_W-1:0]  peer_z;
        logic        [HALF_W-1:0] peer_half_x;
        logic        [HALF_W-1:0] peer_half_y;
        logic        [HALF_W-1:0] peer_half_z;
    } pair_t;

    // one resolution as seen on the output channel
    typedef struct packed {
        logic                     hit;
        logic        [AXIS_W-1:0] push_axis;
        logic signed [MOVE_W-1:0] push_amount;
        logic signed [POS_W-1:0]  new_x;
        logic signed [POS_W-1:0]  new_y;
        logic signed [POS_W-1:0]  new_z;
    } resolve_t;

    // bench copy of the own half-extent registers
    typedef struct packed {
        logic [HALF_W-1:0] hx;
        logic [HALF_W-1:0] hy;
        logic [HALF_W-1:0] hz;
    } half_cfg_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic        [IDX_W-1:0]   cfg_addr = '0;
    logic        [HALF_W-1:0]  cfg_wdata = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    pair_t                     drv_pair = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      hit;
    logic        [AXIS_W-1:0]  push_axis;
    logic signed [MOVE_W-1:0]  push_amount;
    logic signed [POS_W-1:0]   new_x;
    logic signed [POS_W-1:0]   new_y;
    logic signed [POS_W-1:0]   new_z;

    half_cfg_t  half_cfg = '{HALF_ONE, HALF_ONE, HALF_ONE};

    pair_t      pair_q[$];      // box pairs waiting for the driver
    resolve_t   resolved_q[$];  // predicted resolutions, oldest first

    // traffic shaping, in percent per cycle
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       hold_output = 1'b0;   // receiver held off for the fill test

    int         mismatches = 0;
    int         pairs_done = 0;
    int         hits_seen = 0;
    int         axis_seen[3] = '{0, 0, 0};
    int         settings_run = 1;

    aabb_collide_resolve u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .own_x       (drv_pair.own_x),
        .own_y       (drv_pair.own_y),
        .own_z       (drv_pair.own_z),
        .peer_x      (drv_pair.peer_x),
        .peer_y      (drv_pair.peer_y),
        .peer_z      (drv_pair.peer_z),
        .peer_half_x (drv_pair.peer_half_x),
        .peer_half_y (drv_pair.peer_half_y),
        .peer_half_z (drv_pair.peer_half_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .push_axis   (push_axis),
        .push_amount (push_amount),
        .new_x       (new_x),
        .new_y       (new_y),
        .new_z       (new_z)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic longint clamp_signed(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // round down to the unit grid; two's complement mask works for negatives
    function automatic longint grid_floor(longint v);
        return v & -GRID_UNIT;
    endfunction

    // full resolve of one pair against the current own half extents
    function automatic resolve_t resolve_pair(pair_t p, half_cfg_t c);
        longint own[3];
        longint peer[3];
        longint ha[3];
        longint hb[3];
        longint ov[3];
        longint min_a, max_a, min_b, max_b, target, move;
        int ax;
        resolve_t r;
        own  = '{$signed(p.own_x), $signed(p.own_y), $signed(p.own_z)};
        peer = '{$signed(p.peer_x), $signed(p.peer_y), $signed(p.peer_z)};
        ha   = '{longint'(c.hx), longint'(c.hy), longint'(c.hz)};
        hb   = '{longint'(p.peer_half_x), longint'(p.peer_half_y),
                 longint'(p.peer_half_z)};
        r.hit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            min_a = own[i] - ha[i];
            max_a = own[i] + ha[i];
            min_b = peer[i] - hb[i];
            max_b = peer[i] + hb[i];
            // touching counts as a hit
            if (max_a < min_b || min_a > max_b)
                r.hit = 1'b0;
            ov[i] = ((max_a < max_b) ? max_a : max_b) - ((min_a > min_b) ? min_a : min_b);
            if (ov[i] < 0)
                ov[i] = 0;
        end
        // smallest overlap wins, ties to x then y
        if (ov[0] <= ov[1] && ov[0] <= ov[2])
        begin
            ax = 0;
            r.push_axis = AXIS_X;
        end
        else if (ov[1] <= ov[2])
        begin
            ax = 1;
            r.push_axis = AXIS_Y;
        end
        else
        begin
            ax = 2;
            r.push_axis = AXIS_Z;
        end
        // equal centers take the ceil side
        if (own[ax] > peer[ax])
            target = grid_floor(own[ax] + ov[ax]);
        else
            target = -grid_floor(-(own[ax] - ov[ax]));
        move = clamp_signed(target - own[ax], MOVE_W);
        own[ax] = clamp_signed(own[ax] + move, POS_W);
        r.push_amount = MOVE_W'(move);
        r.new_x = POS_W'(own[0]);
        r.new_y = POS_W'(own[1]);
        r.new_z = POS_W'(own[2]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic pair_t make_pair(
        logic signed [POS_W-1:0] ox, logic signed [POS_W-1:0] oy,
        logic signed [POS_W-1:0] oz, logic signed [POS_W-1:0] px,
        logic signed [POS_W-1:0] py, logic signed [POS_W-1:0] pz,
        logic [HALF_W-1:0] hx, logic [HALF_W-1:0] hy, logic [HALF_W-1:0] hz);
        return '{ox, oy, oz, px, py, pz, hx, hy, hz};
    endfunction

    function automatic logic signed [POS_W-1:0] edge_pos();
        case ($urandom_range(5))
            0:       return POS_MAX;
            1:       return POS_MIN;
            2:       return '0;
            3:       return '1;
            4:       return POS_W'(GRID_UNIT);
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic logic [HALF_W-1:0] edge_half();
        case ($urandom_range(3))
            0:       return '0;
            1:       return HALF_MAX;
            2:       return HALF_ONE;
            default: return HALF_W'($urandom);
        endcase
    endfunction

    // peer center close to the own one, within four grid units
    function automatic logic signed [POS_W-1:0] near_offset();
        int d;
        d = int'($urandom_range(0, 2048)) - 1024;
        return POS_W'(d);
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int unsigned mode;
        mode = $urandom_range(99);
        p.own_x = POS_W'($urandom);
        p.own_y = POS_W'($urandom);
        p.own_z = POS_W'($urandom);
        p.peer_x = POS_W'($urandom);
        p.peer_y = POS_W'($urandom);
        p.peer_z = POS_W'($urandom);
        p.peer_half_x = HALF_W'($urandom);
        p.peer_half_y = HALF_W'($urandom);
        p.peer_half_z = HALF_W'($urandom);
        if (mode < 55)
        begin
            // neighbors with small peers: most of these touch somewhere
            p.peer_x = p.own_x + near_offset();
            p.peer_y = p.own_y + near_offset();
            p.peer_z = p.own_z + near_offset();
            p.peer_half_x = HALF_W'($urandom_range(0, 2047));
            p.peer_half_y = HALF_W'($urandom_range(0, 2047));
            p.peer_half_z = HALF_W'($urandom_range(0, 2047));
            if ($urandom_range(7) == 0)
                p.peer_y = p.own_y;
        end
        else if (mode >= 80)
        begin
            p = make_pair(edge_pos(), edge_pos(), edge_pos(),
                          edge_pos(), edge_pos(), edge_pos(),
                          edge_half(), edge_half(), edge_half());
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued pairs, predicts each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                resolved_q.push_back(resolve_pair(drv_pair, half_cfg));
            // load the next pair only once the current one is gone
            if (!in_valid || in_ready)
            begin
                if (pair_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_pair <= pair_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            mismatches++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        resolve_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (resolved_q.size() == 0)
                begin
                    mismatches++;
                    $error("result item with no box pair outstanding");
                end
                else
                begin
                    want = resolved_q.pop_front();
                    check_field("hit", want.hit, hit);
                    check_field("push_axis", want.push_axis, push_axis);
                    check_field("push_amount", want.push_amount, push_amount);
                    check_field("new_x", want.new_x, new_x);
                    check_field("new_y", want.new_y, new_y);
                    check_field("new_z", want.new_z, new_z);
                    pairs_done++;
                    hits_seen += want.hit;
                    axis_seen[want.push_axis]++;
                end
            end
            out_ready <= !hold_output && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    // wait for the pipe to empty, then let the last stage settle;
    // sampled on the falling edge so the driver's updates have landed
    task automatic drain();
        while (pair_q.size() != 0 || in_valid || resolved_q.size() != 0)
            @(negedge clk);
        repeat (DUT_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [HALF_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_OWN_HALF_X: half_cfg.hx = val;
            REG_OWN_HALF_Y: half_cfg.hy = val;
            REG_OWN_HALF_Z: half_cfg.hz = val;
            default: ;
        endcase
    endtask

    task automatic set_halves(logic [HALF_W-1:0] hx, logic [HALF_W-1:0] hy,
                              logic [HALF_W-1:0] hz);
        write_reg(REG_OWN_HALF_X, hx);
        write_reg(REG_OWN_HALF_Y, hy);
        write_reg(REG_OWN_HALF_Z, hz);
        settings_run++;
    endtask

    task automatic run_random(int n, int send_pct, int recv_pct);
        @(posedge clk);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
        repeat (n) pair_q.push_back(random_pair());
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pairs at the reset half extents (1.0 each)
        // identical centers, zero peer: zero move via the ceil side
        pair_q.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // everything at the top of range
        pair_q.push_back(make_pair(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                                   HALF_MAX, HALF_MAX, HALF_MAX));
        // far apart on every axis, no hit
        pair_q.push_back(make_pair(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX,
                                   0, 0, 0));
        // snap pushes past the top: new_x saturates high
        pair_q.push_back(make_pair(POS_MAX, POS_MAX, POS_MAX,
                                   POS_MAX - POS_W'(1), POS_MAX - POS_W'(1),
                                   POS_MAX - POS_W'(1),
                                   HALF_MAX, HALF_MAX, HALF_MAX));
        // and past the bottom: new_x saturates low
        pair_q.push_back(make_pair(POS_MIN, POS_MIN, POS_MIN,
                                   POS_MIN + POS_W'(1), POS_MIN + POS_W'(1),
                                   POS_MIN + POS_W'(1),
                                   HALF_MAX, HALF_MAX, HALF_MAX));
        // separated on y only, then z only
        pair_q.push_back(make_pair(0, 0, 0, 0, 5000, 0, 256, 256, 256));
        pair_q.push_back(make_pair(0, 0, 0, 0, 0, 5000, 256, 256, 256));
        // y and z tie below x: y wins
        pair_q.push_back(make_pair(0, 0, 0, 0, 400, -400, 1024, 256, 256));
        // z is the shallowest axis of a real hit
        pair_q.push_back(make_pair(0, 0, -30, 0, 0, 300, 256, 256, 100));
        // faces exactly touching on x
        pair_q.push_back(make_pair(0, 0, 0, 512, 0, 0, 256, 256, 256));
        // off-grid centers, floor side and ceil side
        pair_q.push_back(make_pair(300, 0, 0, 100, 0, 0, 50, 256, 256));
        pair_q.push_back(make_pair(-300, 0, 0, -100, 0, 0, 50, 256, 256));
        pair_q.push_back(make_pair(128, 77, -5, 0, 0, 0, 0, 0, 0));
        // huge peer around a box at the origin
        pair_q.push_back(make_pair(0, 0, 0, 0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX));
        // alternating bit patterns, both phases
        pair_q.push_back(make_pair(24'h555555, 24'h555555, 24'h555555,
                                   24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA,
                                   22'h155555, 22'h155555, 22'h155555));
        pair_q.push_back(make_pair(24'hAAAAAA, 24'hAAAAAA, 24'hAAAAAA,
                                   24'h555555, 24'h555555, 24'h555555,
                                   22'h2AAAAA, 22'h2AAAAA, 22'h2AAAAA));
        drain();

        // reset extents, no idling
        run_random(200, 0, 0);

        // zero own extents; a write to the unmapped index must change nothing
        write_reg(REG_NONE, HALF_W'($urandom));
        set_halves('0, '0, '0);
        run_random(200, 71, 0);

        // largest extents, receiver stalling
        set_halves(HALF_MAX, HALF_MAX, HALF_MAX);
        run_random(200, 0, 71);

        // small random extents, both sides idling
        set_halves(HALF_W'($urandom_range(0, 4095)), HALF_W'($urandom_range(0, 4095)),
                   HALF_W'($urandom_range(0, 4095)));
        run_random(200, 26, 26);

        // mixed extents; first fill the pipe against a held-off receiver
        set_halves('0, HALF_MAX, HALF_W'(3 * HALF_ONE));
        @(posedge clk);
        send_idle_pct <= 0;
        recv_stall_pct <= 0;
        hold_output <= 1'b1;
        repeat (40) pair_q.push_back(random_pair());
        repeat (150) @(posedge clk);
        hold_output <= 1'b0;
        drain();
        run_random(200, 0, 0);

        // random full-range extents, both sides idling
        set_halves(HALF_W'($urandom), HALF_W'($urandom), HALF_W'($urandom));
        run_random(200, 26, 26);

        $display("Resolved %0d box pairs under %0d half-extent settings, %0d of them hits.",
                 pairs_done, settings_run, hits_seen);
        $display("Push axis chosen: x %0d, y %0d, z %0d; %0d field mismatches.",
                 axis_seen[0], axis_seen[1], axis_seen[2], mismatches);
        if (mismatches == 0)
            $display("[aabb_collide_resolve] OK");
        else
            $display("[aabb_collide_resolve] ERROR");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("[aabb_collide_resolve] ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/acr_pkg.sv
hdl/acr_axis_ovl.sv
hdl/acr_snap.sv
hdl/aabb_collide_resolve.sv
sim/aabb_collide_resolve_test.sv
